FILE: src/upi_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the pose integrator.
package upi_pkg;

  localparam int VEL_W      = 16;
  localparam int RATE_W     = 20;
  localparam int DT_W       = 16;
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 16;
  localparam int RAD_W      = 24;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 64;
  localparam int VEC_W      = 34;
  localparam int ATAN_W     = 30;
  localparam int ATAN_IDX_W = 5;
  localparam int TRIG_W     = 32;
  localparam int SQ_W       = 49;
  localparam int DIST_W     = 33;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ADV_SH     = 38;

  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic signed [POS_W-1:0]  GOAL_X_RST   = -32'sd262144;
  localparam logic signed [POS_W-1:0]  GOAL_Y_RST   = -32'sd65536;
  localparam logic [RAD_W-1:0]         RADIUS_RST   = 24'd13107;
  localparam logic [23:0]              HEAD_RST24   = 24'd7922688;
  localparam logic signed [VEC_W-1:0]  CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [PROD_W-1:0] ADV_RND      = 64'sh0000_0020_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HMUL,
    S_HUPD,
    S_VDT,
    S_CORD,
    S_XADD,
    S_YADD,
    S_EX,
    S_EY,
    S_RR,
    S_CMP,
    S_OUT
  } state_t;

  function automatic logic [ATAN_W-1:0] upi_atan(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] r;
    unique case (idx)
      5'd0:    r = 30'h20000000;
      5'd1:    r = 30'h12E4051E;
      5'd2:    r = 30'h09FB385B;
      5'd3:    r = 30'h051111D4;
      5'd4:    r = 30'h028B0D43;
      5'd5:    r = 30'h0145D7E1;
      5'd6:    r = 30'h00A2F61E;
      5'd7:    r = 30'h00517C55;
      5'd8:    r = 30'h0028BE53;
      5'd9:    r = 30'h00145F2F;
      5'd10:   r = 30'h000A2F98;
      5'd11:   r = 30'h000517CC;
      5'd12:   r = 30'h00028BE6;
      5'd13:   r = 30'h000145F3;
      5'd14:   r = 30'h0000A2FA;
      5'd15:   r = 30'h0000517D;
      5'd16:   r = 30'h000028BE;
      5'd17:   r = 30'h0000145F;
      5'd18:   r = 30'h00000A30;
      5'd19:   r = 30'h00000518;
      5'd20:   r = 30'h0000028C;
      5'd21:   r = 30'h00000146;
      5'd22:   r = 30'h000000A3;
      5'd23:   r = 30'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/upi_channels.sv
// Valid/ready channel interfaces for the input word and the result word.
interface upi_in_if import upi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VEL_W-1:0]  linear_velocity;
  logic signed [RATE_W-1:0] turn_rate;
  logic [DT_W-1:0]          elapsed_time;

  modport source(output valid, linear_velocity, turn_rate, elapsed_time, input ready);
  modport sink(input valid, linear_velocity, turn_rate, elapsed_time, output ready);
endinterface

interface upi_out_if import upi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [HEAD_W-1:0] heading;
  logic                     goal_reached;

  modport source(output valid, pos_x, pos_y, heading, goal_reached, input ready);
  modport sink(input valid, pos_x, pos_y, heading, goal_reached, output ready);
endinterface

FILE: src/upi_mul.sv
// Shared signed 32x32 multiplier with registered product.
module upi_mul import upi_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p_r
);

  logic signed [PROD_W-1:0] p_nxt;

  assign p_nxt = PROD_W'(a) * PROD_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

FILE: src/upi_cordic.sv
// Iterative CORDIC rotator: one micro-rotation per cycle on a shared step unit.
module upi_cordic import upi_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ANGLE_BITS-1:0]    angle,
  output logic                     busy,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  localparam int CW = $clog2(CORDIC_STEPS);

  logic               busy_r, busy_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [VEC_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic               flip_r, flip_nxt;
  logic [31:0]        a32;
  logic               flip_in;
  logic [31:0]        a32f;
  logic signed [VEC_W-1:0] xs, ys, at, cx, sy;

  always_comb begin
    a32      = 32'(angle) << (32 - ANGLE_BITS);
    flip_in  = a32[31] ^ a32[30];
    a32f     = {a32[31] ^ flip_in, a32[30:0]};
    xs       = x_r >>> cnt_r;
    ys       = y_r >>> cnt_r;
    at       = $signed({{(VEC_W-ATAN_W){1'b0}}, upi_atan(ATAN_IDX_W'(cnt_r))});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    flip_nxt = flip_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = VEC_W'($signed(a32f));
      flip_nxt = flip_in;
    end else if (busy_r) begin
      if (!z_r[VEC_W-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign cx    = flip_r ? -x_r : x_r;
  assign sy    = flip_r ? -y_r : y_r;
  assign cos_o = cx[TRIG_W-1:0];
  assign sin_o = sy[TRIG_W-1:0];
  assign busy  = busy_r;

endmodule

FILE: src/unicycle_pose_integrator_unit.sv
// Unicycle pose integrator top level: sequencer, pose state, goal test and result register.
// One word is in flight at a time: a new word is taken only in the idle state, once the CORDIC
// iterations and shared multiplier passes for the last word are done; a finished result waits
// in its own register while the next word is taken. Reset: synchronous, active low; pose to
// origin, heading to 170 degrees, flag cleared, goal registers to their defaults.
module unicycle_pose_integrator_unit import upi_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  upi_in_if.sink                in_ch,
  upi_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SH = 32 - ANGLE_BITS;
  localparam logic [ANGLE_BITS-1:0] HEAD_RST = ANGLE_BITS'(HEAD_RST24 >> (24 - ANGLE_BITS));
  localparam logic [36:0] HRND = 37'(1) << (SH - 1);

  function automatic logic signed [POS_W-1:0] advance(
    input logic signed [POS_W-1:0]  pos,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] t;
    logic signed [POS_W+1:0]  r;
    t = p + ADV_RND;
    r = (POS_W+2)'(pos) + (POS_W+2)'($signed(t[PROD_W-1:ADV_SH]));
    if (r[POS_W+1:POS_W-1] != 3'b000 && r[POS_W+1:POS_W-1] != 3'b111) begin
      return r[POS_W+1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return r[POS_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic signed [POS_W-1:0]  goal_x_r, goal_y_r;
  logic [RAD_W-1:0]         radius_r;
  logic signed [POS_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic [ANGLE_BITS-1:0]    head_r, head_nxt;
  logic                     flag_r, flag_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic signed [VEL_W-1:0]  v_r;
  logic signed [RATE_W-1:0] w_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [MUL_W-1:0]  vdt_r, vdt_nxt;
  logic [SQ_W-1:0]          sq_r, sq_nxt;
  logic signed [POS_W-1:0]  ox_r, oy_r;
  logic signed [HEAD_W-1:0] oh_r;
  logic                     og_r;
  logic                     load_out;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     cord_start, cord_busy;
  logic signed [TRIG_W-1:0] cos_v, sin_v;

  logic [36:0]              hsum;
  logic signed [DIST_W-1:0] ex, ey;
  logic [DIST_W-1:0]        absx, absy;
  logic                     near;
  logic [23:0]              h24;
  logic signed [MUL_W-1:0]  dt_op;

  upi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  upi_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .angle (head_r),
    .busy  (cord_busy),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  always_comb begin
    hsum  = prod[36:0] + HRND;
    ex    = DIST_W'(goal_x_r) - DIST_W'(x_r);
    ey    = DIST_W'(goal_y_r) - DIST_W'(y_r);
    absx  = ex[DIST_W-1] ? DIST_W'(-ex) : DIST_W'(ex);
    absy  = ey[DIST_W-1] ? DIST_W'(-ey) : DIST_W'(ey);
    near  = (absx[DIST_W-1:24] == '0) && (absy[DIST_W-1:24] == '0);
    h24   = 24'(head_r) << (24 - ANGLE_BITS);
    dt_op = $signed({{(MUL_W-DT_W){1'b0}}, dt_r});
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    head_nxt      = head_r;
    flag_nxt      = flag_r;
    vdt_nxt       = vdt_r;
    sq_nxt        = sq_r;
    out_valid_nxt = out_valid_r;
    load_out      = 1'b0;
    cord_start    = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_HMUL;
        end
      end
      S_HMUL: begin
        mul_a     = MUL_W'(w_r);
        mul_b     = dt_op;
        state_nxt = S_HUPD;
      end
      S_HUPD: begin
        head_nxt  = head_r + hsum[SH +: ANGLE_BITS];
        mul_a     = MUL_W'(v_r);
        mul_b     = dt_op;
        state_nxt = S_VDT;
      end
      S_VDT: begin
        vdt_nxt    = prod[MUL_W-1:0];
        cord_start = 1'b1;
        state_nxt  = S_CORD;
      end
      S_CORD: begin
        mul_a = vdt_r;
        mul_b = cos_v;
        if (!cord_busy) begin
          state_nxt = S_XADD;
        end
      end
      S_XADD: begin
        x_nxt     = advance(x_r, prod);
        mul_a     = vdt_r;
        mul_b     = sin_v;
        state_nxt = S_YADD;
      end
      S_YADD: begin
        y_nxt     = advance(y_r, prod);
        state_nxt = S_EX;
      end
      S_EX: begin
        mul_a     = $signed({8'b0, absx[23:0]});
        mul_b     = $signed({8'b0, absx[23:0]});
        state_nxt = S_EY;
      end
      S_EY: begin
        sq_nxt    = SQ_W'(prod[47:0]);
        mul_a     = $signed({8'b0, absy[23:0]});
        mul_b     = $signed({8'b0, absy[23:0]});
        state_nxt = S_RR;
      end
      S_RR: begin
        sq_nxt    = sq_r + SQ_W'(prod[47:0]);
        mul_a     = $signed({8'b0, radius_r});
        mul_b     = $signed({8'b0, radius_r});
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (near && (sq_r <= SQ_W'(prod[47:0]))) begin
          flag_nxt = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_r         <= '0;
      y_r         <= '0;
      head_r      <= HEAD_RST;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      goal_x_r    <= GOAL_X_RST;
      goal_y_r    <= GOAL_Y_RST;
      radius_r    <= RADIUS_RST;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      head_r      <= head_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GOAL_X: goal_x_r <= $signed(cfg_wdata[POS_W-1:0]);
          CFG_GOAL_Y: goal_y_r <= $signed(cfg_wdata[POS_W-1:0]);
          CFG_RADIUS: radius_r <= cfg_wdata[RAD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      v_r  <= in_ch.linear_velocity;
      w_r  <= in_ch.turn_rate;
      dt_r <= in_ch.elapsed_time;
    end
    vdt_r <= vdt_nxt;
    sq_r  <= sq_nxt;
    if (load_out) begin
      ox_r <= x_r;
      oy_r <= y_r;
      oh_r <= $signed(h24[23:8]);
      og_r <= flag_r;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pos_x        = ox_r;
  assign out_ch.pos_y        = oy_r;
  assign out_ch.heading      = oh_r;
  assign out_ch.goal_reached = og_r;

endmodule

FILE: tb/unicycle_pose_integrator_unit_tb.sv
// Self-checking testbench for the unicycle pose integrator: pose prediction, stimulus, checks.
package upi_tb_pkg;
  import upi_pkg::*;

  localparam longint CORDIC_K     = 64'sd652032874;
  localparam int     CORDIC_ITERS = 16;
  localparam longint POS_MAX      = 64'sd2147483647;
  localparam longint POS_MIN      = -64'sd2147483648;
  localparam longint NEAR_LIMIT   = 64'sd16777216;
  localparam longint MOVE_ROUND   = 64'sd137438953472;
  localparam int     MAX_REPORTS  = 200;

  localparam longint ATAN_TURNS [0:15] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [HEAD_W-1:0] heading;
    logic                     reached;
  } pose_word_t;

  class pose_ledger;
    longint            x_pos;
    longint            y_pos;
    logic [HEAD_W-1:0] heading;
    bit                reached;
    longint            goal_x;
    longint            goal_y;
    longint            radius;
    pose_word_t        pending_poses[$];
    int                mismatches;
    int                words_in;
    int                words_out;
    int                flagged_words;

    function new();
      x_pos = 0;
      y_pos = 0;
      heading = 16'd30948;
      reached = 1'b0;
      goal_x = -64'sd262144;
      goal_y = -64'sd65536;
      radius = 64'sd13107;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GOAL_X: goal_x = longint'(signed'(data));
        CFG_GOAL_Y: goal_y = longint'(signed'(data));
        CFG_RADIUS: radius = longint'(data[RAD_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint moved(longint pos, longint prod);
      longint r;
      r = pos + ((prod + MOVE_ROUND) >>> 38);
      if (r > POS_MAX) r = POS_MAX;
      if (r < POS_MIN) r = POS_MIN;
      return r;
    endfunction

    function void note_motion(logic signed [VEL_W-1:0] v, logic signed [RATE_W-1:0] w,
                              logic [DT_W-1:0] dt);
      longint      turn;
      longint      cx;
      longint      cy;
      longint      z;
      longint      xs;
      longint      ys;
      longint      vdt;
      longint      ex;
      longint      ey;
      logic [31:0] a32;
      bit          flip;
      pose_word_t  next_pose;
      turn = longint'(w) * longint'(dt) + 64'sd32768;
      heading = heading + turn[31:16];
      a32 = {heading, 16'h0000};
      flip = a32[31] ^ a32[30];
      if (flip) a32[31] = ~a32[31];
      z = longint'(signed'(a32));
      cx = CORDIC_K;
      cy = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (z >= 0) begin
          cx = cx - ys;
          cy = cy + xs;
          z = z - ATAN_TURNS[i];
        end else begin
          cx = cx + ys;
          cy = cy - xs;
          z = z + ATAN_TURNS[i];
        end
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      vdt = longint'(v) * longint'(dt);
      x_pos = moved(x_pos, vdt * cx);
      y_pos = moved(y_pos, vdt * cy);
      ex = goal_x - x_pos;
      ey = goal_y - y_pos;
      if (ex < 0) ex = -ex;
      if (ey < 0) ey = -ey;
      if (ex < NEAR_LIMIT && ey < NEAR_LIMIT) begin
        if (ex * ex + ey * ey <= radius * radius) reached = 1'b1;
      end
      next_pose = pose_word_t'{x_pos[31:0], y_pos[31:0], heading, reached};
      pending_poses = {pending_poses, next_pose};
      words_in++;
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("%s: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    function void check_pose(pose_word_t got);
      pose_word_t want;
      words_out++;
      if (got.reached === 1'b1) flagged_words++;
      if (pending_poses.size() == 0) begin
        mismatches++;
        $error("result word with no pose pending: x %0d y %0d", got.x, got.y);
        return;
      end
      want = pending_poses.pop_front();
      if ($isunknown(got)) begin
        mismatches++;
        $error("result word carries unknown bits: %h", got);
        return;
      end
      compare_field("pos_x", longint'(want.x), longint'(got.x));
      compare_field("pos_y", longint'(want.y), longint'(got.y));
      compare_field("heading", longint'(want.heading), longint'(got.heading));
      compare_field("goal_reached", longint'(want.reached), longint'(got.reached));
    endfunction
  endclass

endpackage

module unicycle_pose_integrator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import upi_pkg::*;
  import upi_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_MARK_A    = 150;
  localparam int HOLD_MARK_B    = 1000;
  localparam int DRAIN_TAIL     = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  upi_in_if  in_ch();
  upi_out_if out_ch();

  unicycle_pose_integrator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pose_ledger ledger = new();
  bit         steady = 1'b0;
  int         settings_used = 0;
  int         idle_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic pause_sender();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      in_ch.linear_velocity = VEL_W'($urandom);
      in_ch.turn_rate = RATE_W'($urandom);
      in_ch.elapsed_time = DT_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_word(input logic signed [VEL_W-1:0] v, input logic signed [RATE_W-1:0] w,
                           input logic [DT_W-1:0] dt);
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.linear_velocity = v;
    in_ch.turn_rate = w;
    in_ch.elapsed_time = dt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    ledger.note_motion(v, w, dt);
    pause_sender();
  endtask

  task automatic send_random();
    logic signed [VEL_W-1:0]  v;
    logic signed [RATE_W-1:0] w;
    logic [DT_W-1:0]          dt;
    case ($urandom_range(9))
      0:       v = 16'h8000;
      1:       v = 16'h7FFF;
      2, 3, 4: v = VEL_W'($urandom_range(1024)) - VEL_W'(512);
      default: v = VEL_W'($urandom);
    endcase
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = 20'h80000;
      2:       w = 20'h7FFFF;
      3, 4, 5: w = RATE_W'($urandom_range(8192)) - RATE_W'(4096);
      default: w = RATE_W'($urandom);
    endcase
    case ($urandom_range(9))
      0:       dt = '0;
      1:       dt = 16'hFFFF;
      2, 3, 4: dt = DT_W'($urandom_range(4096));
      default: dt = DT_W'($urandom);
    endcase
    send_word(v, w, dt);
  endtask

  // land the heading exactly on target in one word
  task automatic steer_to(input logic [HEAD_W-1:0] target, input logic signed [VEL_W-1:0] v);
    logic signed [HEAD_W-1:0] delta;
    delta = target - ledger.heading;
    send_word(v, RATE_W'(2 * int'(delta)), 16'd32768);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (ledger.pending_poses.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    ledger.write_register(idx, data);
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      ledger.check_pose(pose_word_t'{out_ch.pos_x, out_ch.pos_y, out_ch.heading,
                                     out_ch.goal_reached});
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int next_hold;
    stall_left = 0;
    hold_left = 0;
    next_hold = HOLD_MARK_A;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && next_hold > 0 && ledger.words_out >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = (next_hold == HOLD_MARK_A) ? HOLD_MARK_B : 0;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int     straight;
    longint gx;
    in_ch.valid = 1'b0;
    in_ch.linear_velocity = '0;
    in_ch.turn_rate = '0;
    in_ch.elapsed_time = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed corners under reset goal settings
    send_word('0, '0, '0);
    send_word(16'h7FFF, '0, 16'hFFFF);
    send_word(16'h8000, '0, 16'hFFFF);
    send_word(16'h7FFF, 20'h7FFFF, 16'hFFFF);
    send_word(16'h8000, 20'h80000, 16'hFFFF);
    send_word(16'sd256, 20'sd1, 16'd32768);
    send_word(16'sd256, 20'hFFFFF, 16'd32768);
    send_word(16'sd256, 20'sd1, 16'd32767);
    send_word(16'h7FFF, 20'h7FFFF, '0);
    steer_to(16'h8000, 16'h7FFF);
    send_word(16'h7FFF, '0, 16'hFFFF);
    steer_to(16'h7FFF, 16'sd4096);
    steer_to(16'h4000, 16'sd4096);
    steer_to(16'h3FFF, 16'h8000);
    steer_to(16'h0000, 16'sd4096);
    steer_to(16'hC000, 16'h7FFF);
    steer_to(16'hBFFF, 16'sd4096);
    steer_to(16'hC001, 16'h8000);
    send_word(16'sd1, '0, 16'd1);
    send_word(16'hFFFF, '0, 16'hFFFF);
    send_word(16'h8000, '0, 16'd1);

    // goal in a far corner, widest radius
    drain();
    write_reg(CFG_GOAL_X, 32'h7FFF_FFFF);
    write_reg(CFG_GOAL_Y, 32'h8000_0000);
    write_reg(CFG_RADIUS, {8'($urandom), 24'hFFFFFF});
    write_reg(CFG_SPARE, $urandom);
    repeat (350) send_random();

    // straight run into positive x saturation, no idling
    drain();
    write_reg(CFG_GOAL_X, 32'h8000_0000);
    write_reg(CFG_GOAL_Y, 32'h7FFF_FFFF);
    write_reg(CFG_RADIUS, 32'd0);
    steady = 1'b1;
    steer_to(16'h0000, 16'h7FFF);
    straight = 0;
    while (ledger.x_pos != POS_MAX && straight < 300) begin
      send_word(16'h7FFF, '0, 16'hFFFF);
      straight++;
    end
    repeat (8) send_word(16'h7FFF, '0, 16'hFFFF);
    repeat (180) send_random();
    steady = 1'b0;

    drain();
    write_reg(CFG_GOAL_X, $urandom);
    write_reg(CFG_GOAL_Y, $urandom);
    write_reg(CFG_RADIUS, 32'd0);
    repeat (400) send_random();

    // axis distance of exactly the near limit must not count as reached
    drain();
    gx = (ledger.x_pos > 0) ? ledger.x_pos - NEAR_LIMIT : ledger.x_pos + NEAR_LIMIT;
    write_reg(CFG_GOAL_X, gx[31:0]);
    write_reg(CFG_GOAL_Y, ledger.y_pos[31:0]);
    write_reg(CFG_RADIUS, 32'h00FF_FFFF);
    send_word(VEL_W'($urandom), RATE_W'($urandom), '0);
    drain();
    gx = (ledger.x_pos > 0) ? gx + 1 : gx - 1;
    write_reg(CFG_GOAL_X, gx[31:0]);
    send_word(VEL_W'($urandom), RATE_W'($urandom), '0);
    repeat (300) send_random();

    drain();
    write_reg(CFG_GOAL_X, $urandom);
    write_reg(CFG_GOAL_Y, $urandom);
    write_reg(CFG_RADIUS, $urandom);
    write_reg(CFG_SPARE, $urandom);
    repeat (350) send_random();

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("Run moved %0d input words and %0d result words through %0d register writes;",
             ledger.words_in, ledger.words_out, settings_used);
    $display("goal flag set in %0d results, position saturation and heading wrap exercised.",
             ledger.flagged_words);
    if (ledger.mismatches == 0 && ledger.pending_poses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
